// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file sma_checker.sv
// depends on nothing; the including module supplies aclk and aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is skipped while reset is asserted
`define SMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds across reset
`define SMA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/sma_pkg.sv =====
// shared types and codes of the stack machine alu
// used by stack_machine_alu and sma_checker; no dependencies
package sma_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned KIND_W    = 4;
    localparam int unsigned DEPTH_W   = 11;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // instruction codes
    localparam logic [KIND_W-1:0] KIND_PUSH = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SUB  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_MUL  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DIV  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MAX  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MIN  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NEG  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_DUP  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SWAP = 4'd9;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZ  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_DIVEND,
        ST_SWAP2,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/stack_machine_alu.sv =====
// evaluation stack machine: stack memory, top-of-stack register, alu and divider
// depends on sma_pkg
//
// usage
//   input channel s_valid/s_ready carries one instruction word (s_kind, s_value);
//   result channel m_valid/m_ready returns one word per instruction with the
//   top of stack, the depth and a status code.
//   one instruction is in flight at a time: s_ready is high only in the idle
//   state. the stack lives in a single-port-write, single-port-read memory
//   with a registered read port; the top entry is also held in a register.
// sequence
//   push, add, sub, mul, max, min, neg, dup and every error case: accept,
//   memory read of the second entry, execute, respond.
//   swap: an extra state after execute for the second memory write.
//   div: the radix-2 divider takes one quotient bit a cycle between execute and respond.
//   m_valid is registered: it rises once the respond state finds the output free.
// reset
//   aresetn (synchronous, active low) empties the stack and drops m_valid;
//   the memory itself is not cleared, only entries below the pointer are used.
// stall
//   a held result waits in the output register; the next word is accepted
//   meanwhile and its own result holds in the respond state until m_ready.
module stack_machine_alu
    import sma_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // instruction channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic        [KIND_W-1:0]   s_kind,
    input  logic signed [DATA_W-1:0]   s_value,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DATA_W-1:0]   m_top_value,
    output logic        [DEPTH_W-1:0]  m_depth,
    output logic        [STATUS_W-1:0] m_status
);

    localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned PTR_W = $clog2(STACK_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_TWO  = PTR_W'(2);
    localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);

    // stack memory
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    // control state
    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       sp_reg, sp_next;
    logic                   m_valid_reg, m_valid_next;

    // datapath registers
    logic [KIND_W-1:0]      kind_reg;
    logic [DATA_W-1:0]      value_reg;
    logic [DATA_W-1:0]      tos_reg, tos_next;      // copy of entry sp-1
    logic [DATA_W-1:0]      rd_data_reg;            // entry sp-2 after the read cycle
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [DATA_W-1:0]      quo_reg, rem_reg, dvs_reg;
    logic                   quo_neg_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DATA_W-1:0]      m_top_value_reg;
    logic [DEPTH_W-1:0]     m_depth_reg;
    logic [STATUS_W-1:0]    m_status_reg;

    // memory port controls
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DATA_W-1:0]      wr_data;
    logic [AW-1:0]          rd_addr;

    // execute-stage decode
    logic                   accept;
    logic                   out_free;
    logic                   sp_empty, sp_lt2, sp_full;
    logic                   div_start;
    logic                   swap_go;
    logic [DATA_W-1:0]      op_a, op_b;
    logic [DATA_W-1:0]      mul_lo;
    logic [DATA_W-1:0]      alu_res;
    logic [DATA_W-1:0]      quo_res;

    // divider step
    logic [DATA_W:0]        div_trial;
    logic [DATA_W-1:0]      dvd_mag, dvs_mag;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign sp_empty = (sp_reg == '0);
    assign sp_lt2   = (sp_reg < PTR_TWO);
    assign sp_full  = (sp_reg >= PTR_FULL);

    // a is the top entry, b the one below it
    assign op_a = tos_reg;
    assign op_b = rd_data_reg;

    assign div_start = (kind_reg == KIND_DIV) && !sp_lt2 && (op_b != '0);
    assign swap_go   = (kind_reg == KIND_SWAP) && !sp_lt2;

    // second entry is read in the cycle after acceptance; all writes of the
    // previous word have landed by then, so no forwarding path is needed
    assign rd_addr = AW'(sp_reg - PTR_TWO);

    assign mul_lo = op_a * op_b;

    always_comb begin
        case (kind_reg)
            KIND_ADD: alu_res = op_a + op_b;
            KIND_SUB: alu_res = op_a - op_b;
            KIND_MUL: alu_res = mul_lo;
            KIND_MAX: alu_res = ($signed(op_a) > $signed(op_b)) ? op_a : op_b;
            KIND_MIN: alu_res = ($signed(op_a) < $signed(op_b)) ? op_a : op_b;
            default:  alu_res = '0;
        endcase
    end

    // divider operand magnitudes; -2^31 maps to 2^31, which fits unsigned
    assign dvd_mag = op_a[DATA_W-1] ? (~op_a + 1'b1) : op_a;
    assign dvs_mag = op_b[DATA_W-1] ? (~op_b + 1'b1) : op_b;

    // restoring division, one quotient bit a cycle
    assign div_trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dvs_reg};
    assign quo_res   = quo_neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_READ;
            end
            ST_READ:   state_next = ST_EXEC;
            ST_EXEC: begin
                if (div_start)    state_next = ST_DIV;
                else if (swap_go) state_next = ST_SWAP2;
                else              state_next = ST_DONE;
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_DIVEND;
            end
            ST_DIVEND: state_next = ST_DONE;
            ST_SWAP2:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of each state: ready, memory writes, stack and status updates
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = tos_reg;
        tos_next     = tos_reg;
        sp_next      = sp_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_EXEC: begin
                status_next = STAT_OK;
                case (kind_reg)
                    KIND_PUSH: begin
                        if (sp_full) begin
                            status_next = STAT_OVER;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = AW'(sp_reg);
                            wr_data  = value_reg;
                            tos_next = value_reg;
                            sp_next  = sp_reg + PTR_ONE;
                        end
                    end
                    KIND_ADD, KIND_SUB, KIND_MUL, KIND_MAX, KIND_MIN: begin
                        if (sp_lt2) begin
                            status_next = STAT_UNDER;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = AW'(sp_reg - PTR_TWO);
                            wr_data  = alu_res;
                            tos_next = alu_res;
                            sp_next  = sp_reg - PTR_ONE;
                        end
                    end
                    KIND_DIV: begin
                        if (sp_lt2)            status_next = STAT_UNDER;
                        else if (op_b == '0)   status_next = STAT_DIVZ;
                    end
                    KIND_NEG: begin
                        if (sp_empty) begin
                            status_next = STAT_UNDER;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = AW'(sp_reg - PTR_ONE);
                            wr_data  = ~op_a + 1'b1;
                            tos_next = ~op_a + 1'b1;
                        end
                    end
                    KIND_DUP: begin
                        if (sp_empty) begin
                            status_next = STAT_UNDER;
                        end else if (sp_full) begin
                            status_next = STAT_OVER;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(sp_reg);
                            wr_data = op_a;
                            sp_next = sp_reg + PTR_ONE;
                        end
                    end
                    KIND_SWAP: begin
                        if (sp_lt2) begin
                            status_next = STAT_UNDER;
                        end else begin
                            // old top goes down now, old second becomes top next cycle
                            wr_en    = 1'b1;
                            wr_addr  = AW'(sp_reg - PTR_TWO);
                            wr_data  = op_a;
                            tos_next = op_b;
                        end
                    end
                    default: status_next = STAT_OK;
                endcase
            end
            ST_SWAP2: begin
                wr_en   = 1'b1;
                wr_addr = AW'(sp_reg - PTR_ONE);
                wr_data = tos_reg;
            end
            ST_DIVEND: begin
                wr_en    = 1'b1;
                wr_addr  = AW'(sp_reg - PTR_TWO);
                wr_data  = quo_res;
                tos_next = quo_res;
                sp_next  = sp_reg - PTR_ONE;
            end
            ST_DONE: begin
                if (out_free) m_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            value_reg <= s_value;
        end
        tos_reg    <= tos_next;
        status_reg <= status_next;
        if (state_reg == ST_EXEC) begin
            quo_reg     <= dvd_mag;
            rem_reg     <= '0;
            dvs_reg     <= dvs_mag;
            quo_neg_reg <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            div_cnt_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!div_trial[DATA_W]) begin
                rem_reg <= div_trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_top_value_reg <= sp_empty ? '0 : tos_reg;
            m_depth_reg     <= DEPTH_W'(sp_reg);
            m_status_reg    <= status_reg;
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) stack_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) rd_data_reg <= stack_mem[rd_addr];
    end

    assign m_valid     = m_valid_reg;
    assign m_top_value = m_top_value_reg;
    assign m_depth     = m_depth_reg;
    assign m_status    = m_status_reg;

endmodule

// ===== rtl/sma_checker.sv =====
// port-level checks of stack_machine_alu, bound into stack_machine_alu
// depends on sma_pkg and assert_macros.svh
`include "assert_macros.svh"

module sma_checker
    import sma_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 1024
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [DATA_W-1:0]   m_top_value,
    input logic        [DEPTH_W-1:0]  m_depth,
    input logic        [STATUS_W-1:0] m_status
);

    // a stalled result word stays put
    `SMA_ASSERT(a_m_hold, m_valid && !m_ready |=> m_valid && $stable(m_top_value), "result dropped under stall")

    // one word in flight: ready falls right after an accept
    `SMA_ASSERT(a_one_in_flight, s_valid && s_ready |=> !s_ready, "second word accepted while busy")

    // an empty stack reports a zero top
    `SMA_ASSERT(a_empty_top, m_valid && (m_depth == '0) |-> (m_top_value == '0), "nonzero top on empty stack")

    // overflow only happens on a full stack
    `SMA_ASSERT(a_over_full, m_valid && (m_status == STAT_OVER) |-> (m_depth == DEPTH_W'(STACK_DEPTH)), "overflow below full depth")

    // reset drops the result channel
    `SMA_ASSERT_RST(a_rst_quiet, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind stack_machine_alu sma_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sma_checker (.*);
